/* src/fed_pkg.sv */
// ---------------------------------------------------------------------------
// Feedback echo delay package
// Shared widths, register indexes, reset values, types and the saturation
// helper used by the echo delay core.
// ---------------------------------------------------------------------------
`default_nettype none

package fed_pkg;

   localparam int FED_MAX_DEPTH   = 262144;
   localparam int FED_CHANNELS    = 2;
   localparam int FED_QUEUE_DEPTH = 2;

   localparam int SAMPLE_W    = 24;
   localparam int DELAY_W     = 26;
   localparam int GAIN_W      = 16;
   localparam int LEN_W       = 19;
   localparam int ACT_W       = 2;
   localparam int FRAC_W      = 8;
   localparam int CSR_DATA_W  = 26;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_SAMPLES   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_GAIN        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_LENGTH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_CHANNELS = 3'd4;

   localparam logic [DELAY_W-1:0] RST_DELAY_SAMPLES   = 26'd1228800;
   localparam logic [GAIN_W-1:0]  RST_FEEDBACK_GAIN   = 16'd16384;
   localparam logic [GAIN_W-1:0]  RST_MIX_GAIN        = 16'd16384;
   localparam logic [LEN_W-1:0]   RST_BUFFER_LENGTH   = 19'd240001;
   localparam logic [ACT_W-1:0]   RST_ACTIVE_CHANNELS = 2'd2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [DELAY_W-1:0] delay_samples;
      logic [GAIN_W-1:0]  feedback_gain;
      logic [GAIN_W-1:0]  mix_gain;
      logic [LEN_W-1:0]   buffer_length;
      logic [ACT_W-1:0]   active_channels;
   } cfg_type;

   typedef struct packed {
      sample_type sample;
      logic       channel;
   } rsp_type;

   typedef enum logic {
      OP_PASS,
      OP_ECHO
   } op_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_POS,
      F_IDX,
      F_CLS
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_READ,
      B_INTP,
      B_ECHO,
      B_MUL,
      B_SUM,
      B_PASS
   } back_state_type;

   localparam logic signed [27:0] SAT_MAX = 28'sd8388607;
   localparam logic signed [27:0] SAT_MIN = -28'sd8388608;

   function automatic sample_type sat24(input logic signed [27:0] v);
      sample_type r;
      if (v > SAT_MAX) begin
         r = 24'sh7FFFFF;
      end else if (v < SAT_MIN) begin
         r = 24'sh800000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/fed_csr.sv */
// ---------------------------------------------------------------------------
// Echo delay control registers
// Holds the five configuration registers and applies writes from the
// register port.
// ---------------------------------------------------------------------------
`default_nettype none

module fed_csr import fed_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_DELAY_SAMPLES:   cfg_in.delay_samples   = csr_wdata[DELAY_W-1:0];
            CSR_FEEDBACK_GAIN:   cfg_in.feedback_gain   = csr_wdata[GAIN_W-1:0];
            CSR_MIX_GAIN:        cfg_in.mix_gain        = csr_wdata[GAIN_W-1:0];
            CSR_BUFFER_LENGTH:   cfg_in.buffer_length   = csr_wdata[LEN_W-1:0];
            CSR_ACTIVE_CHANNELS: cfg_in.active_channels = csr_wdata[ACT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_samples   <= RST_DELAY_SAMPLES;
         cfg_ff.feedback_gain   <= RST_FEEDBACK_GAIN;
         cfg_ff.mix_gain        <= RST_MIX_GAIN;
         cfg_ff.buffer_length   <= RST_BUFFER_LENGTH;
         cfg_ff.active_channels <= RST_ACTIVE_CHANNELS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* src/fed_queue.sv */
// ---------------------------------------------------------------------------
// Echo delay queue
// Small first-in first-out buffer of register slots, used between the
// front and back sections and in front of the result port.
// ---------------------------------------------------------------------------
`default_nettype none

module fed_queue import fed_pkg::*; #(
   parameter type entry_type = logic,
   parameter int  DEPTH      = FED_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   entry_type         slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* src/fed_front.sv */
// ---------------------------------------------------------------------------
// Echo delay front section
// Accepts samples, clamps the configuration, works out the read and write
// indexes and decides whether the sample takes the echo path or passes.
// ---------------------------------------------------------------------------
`default_nettype none

module fed_front import fed_pkg::*; #(
   parameter int  MAX_DEPTH = FED_MAX_DEPTH,
   parameter int  CHANNELS  = FED_CHANNELS,
   parameter type job_type  = logic
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       hold,
   input  logic       req_push,
   output logic       req_full,
   input  sample_type req_sample_in,
   input  logic       req_channel,
   output logic       job_push,
   output job_type    job_data,
   input  logic       job_full
);

   localparam int AW      = $clog2(MAX_DEPTH);
   localparam int AW1     = AW + 1;
   localparam int LW      = $clog2(MAX_DEPTH + 1);
   localparam int LCW     = (LW > LEN_W) ? LW : LEN_W;
   localparam int PW      = LW + FRAC_W;
   localparam int DCW     = (PW > DELAY_W) ? PW : DELAY_W;
   localparam int ENTRIES = CHANNELS * MAX_DEPTH;
   localparam int MW      = $clog2(ENTRIES);

   front_state_type   state_ff, state_in;
   sample_type        sample_ff, sample_in;
   logic              chan_ff, chan_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [AW-1:0]     wpe_ff, wpe_in;
   logic [PW-1:0]     dly_ff, dly_in;
   logic [PW-1:0]     pos_ff, pos_in;

   logic              accept;
   logic [LW-1:0]     len_clamp;
   logic [ACT_W-1:0]  act_clamp;
   logic [PW-1:0]     span_m1, span;
   logic [PW:0]       back_diff;
   logic [AW-1:0]     rd_idx, nx_idx, wp_next;
   logic [AW1-1:0]    rd_inc, wp_inc;
   logic [FRAC_W-1:0] frac;
   logic              active, last, pass;

   function automatic logic [MW-1:0] row_addr(input logic ch, input logic [AW-1:0] idx);
      logic [MW-1:0] a;
      a = MW'(idx);
      if (ch) begin
         a = a + MW'(MAX_DEPTH);
      end
      return a;
   endfunction

   assign req_full = (state_ff != F_IDLE) || hold;
   assign accept   = req_push && !req_full;

   // Length and channel count clamps.
   always_comb begin
      if (cfg.buffer_length == '0) begin
         len_clamp = LW'(1);
      end else if (LCW'(cfg.buffer_length) > LCW'(MAX_DEPTH)) begin
         len_clamp = LW'(MAX_DEPTH);
      end else begin
         len_clamp = LW'(cfg.buffer_length);
      end
      if (cfg.active_channels == '0) begin
         act_clamp = ACT_W'(1);
      end else if (4'(cfg.active_channels) > 4'(CHANNELS)) begin
         act_clamp = ACT_W'(CHANNELS);
      end else begin
         act_clamp = cfg.active_channels;
      end
   end

   // Index arithmetic in fixed point with eight fraction bits.
   always_comb begin
      span_m1   = {len_ff - LW'(1), 8'hFF};
      span      = {len_ff, 8'h00};
      back_diff = {1'b0, PW'({wpe_ff, 8'h00})} - {1'b0, dly_ff};
      rd_idx    = pos_ff[AW+FRAC_W-1:FRAC_W];
      frac      = pos_ff[FRAC_W-1:0];
      rd_inc    = {1'b0, rd_idx} + AW1'(1);
      nx_idx    = (rd_inc >= AW1'(len_ff)) ? '0 : rd_inc[AW-1:0];
      wp_inc    = {1'b0, wpe_ff} + AW1'(1);
      wp_next   = (wp_inc >= AW1'(len_ff)) ? '0 : wp_inc[AW-1:0];
      active    = ({1'b0, chan_ff} < act_ff);
      last      = (ACT_W'(chan_ff) == act_ff - ACT_W'(1));
      pass      = !active || (rd_idx == wpe_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (accept) state_in = F_POS;
         F_POS:   state_in = F_IDX;
         F_IDX:   state_in = F_CLS;
         F_CLS:   if (!job_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      sample_in = sample_ff;
      chan_in   = chan_ff;
      len_in    = len_ff;
      act_in    = act_ff;
      wp_in     = wp_ff;
      wpe_in    = wpe_ff;
      dly_in    = dly_ff;
      pos_in    = pos_ff;
      job_push  = 1'b0;

      job_data.op       = pass ? OP_PASS : OP_ECHO;
      job_data.sample   = sample_ff;
      job_data.channel  = chan_ff;
      job_data.rd0_addr = row_addr(chan_ff, rd_idx);
      job_data.rd1_addr = row_addr(chan_ff, nx_idx);
      job_data.wr_addr  = row_addr(chan_ff, wpe_ff);
      job_data.frac     = frac;

      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               sample_in = req_sample_in;
               chan_in   = req_channel;
               len_in    = len_clamp;
               act_in    = act_clamp;
            end
         end
         F_POS: begin
            // A write position left beyond a shortened length restarts at zero.
            wpe_in = (LW'(wp_ff) >= len_ff) ? '0 : wp_ff;
            if (DCW'(cfg.delay_samples) > DCW'(span_m1)) begin
               dly_in = span_m1;
            end else begin
               dly_in = PW'(cfg.delay_samples);
            end
         end
         F_IDX: begin
            pos_in = back_diff[PW] ? back_diff[PW-1:0] + span : back_diff[PW-1:0];
         end
         F_CLS: begin
            if (!job_full) begin
               job_push = 1'b1;
               wp_in    = (active && last) ? wp_next : wpe_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         wp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      chan_ff   <= chan_in;
      len_ff    <= len_in;
      act_ff    <= act_in;
      wpe_ff    <= wpe_in;
      dly_ff    <= dly_in;
      pos_ff    <= pos_in;
   end

endmodule

`default_nettype wire

/* src/fed_back.sv */
// ---------------------------------------------------------------------------
// Echo delay back section
// Owns the delay store. Reads the two neighbor entries, interpolates, forms
// the wet output and the feedback value, and writes the store back.
// ---------------------------------------------------------------------------
`default_nettype none

module fed_back import fed_pkg::*; #(
   parameter int  MAX_DEPTH = FED_MAX_DEPTH,
   parameter int  CHANNELS  = FED_CHANNELS,
   parameter type job_type  = logic
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_valid,
   input  job_type job_data,
   output logic    job_pop,
   output logic    rsp_push,
   output rsp_type rsp_data,
   input  logic    rsp_full,
   output logic    clearing
);

   localparam int ENTRIES = CHANNELS * MAX_DEPTH;
   localparam int MW      = $clog2(ENTRIES);
   localparam logic [MW-1:0] LAST_ENTRY = MW'(ENTRIES - 1);

   back_state_type      state_ff, state_in;
   job_type             job_ff, job_in;
   sample_type          e1_ff, e1_in;
   logic signed [33:0]  prod_ff, prod_in;
   sample_type          echo_ff, echo_in;
   logic signed [41:0]  wet_ff, wet_in;
   logic signed [40:0]  fbk_ff, fbk_in;
   logic                clr_ff, clr_in;
   logic [MW-1:0]       clr_addr_ff, clr_addr_in;

   sample_type          store_mem [ENTRIES];
   sample_type          rd_data_ff;
   logic [MW-1:0]       mem_raddr, mem_waddr;
   logic                mem_wen;
   sample_type          mem_wdata;

   logic                start;
   logic signed [24:0]  diff, dx, echo_sum;
   logic signed [27:0]  y_sum, st_sum;

   assign clearing = clr_ff;
   assign start    = !clr_ff && job_valid && !rsp_full;

   always_comb begin
      diff     = {rd_data_ff[SAMPLE_W-1], rd_data_ff} - {e1_ff[SAMPLE_W-1], e1_ff};
      echo_sum = {e1_ff[SAMPLE_W-1], e1_ff} + prod_ff[32:8];
      dx       = {echo_ff[SAMPLE_W-1], echo_ff} - {job_ff.sample[SAMPLE_W-1], job_ff.sample};
      y_sum    = {{4{job_ff.sample[SAMPLE_W-1]}}, job_ff.sample} + {wet_ff[41], wet_ff[41:15]};
      st_sum   = {{4{job_ff.sample[SAMPLE_W-1]}}, job_ff.sample}
               + {{2{fbk_ff[40]}}, fbk_ff[40:15]};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (start) begin
               state_in = (job_data.op == OP_ECHO) ? B_READ : B_PASS;
            end
         end
         B_READ:  state_in = B_INTP;
         B_INTP:  state_in = B_ECHO;
         B_ECHO:  state_in = B_MUL;
         B_MUL:   state_in = B_SUM;
         B_SUM:   state_in = B_IDLE;
         B_PASS:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      job_in      = job_ff;
      e1_in       = e1_ff;
      prod_in     = prod_ff;
      echo_in     = echo_ff;
      wet_in      = wet_ff;
      fbk_in      = fbk_ff;
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      job_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp_data.sample  = job_ff.sample;
      rsp_data.channel = job_ff.channel;
      mem_raddr   = job_data.rd0_addr;
      mem_wen     = 1'b0;
      mem_waddr   = job_ff.wr_addr;
      mem_wdata   = sat24(st_sum);

      // After reset the whole store is zeroed, one entry per cycle.
      if (clr_ff) begin
         mem_wen     = 1'b1;
         mem_waddr   = clr_addr_ff;
         mem_wdata   = '0;
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ENTRY) begin
            clr_in = 1'b0;
         end
      end

      unique case (state_ff)
         B_IDLE: begin
            if (start) begin
               job_pop = 1'b1;
               job_in  = job_data;
            end
         end
         B_READ: begin
            mem_raddr = job_ff.rd1_addr;
            e1_in     = rd_data_ff;
         end
         B_INTP: begin
            prod_in = $signed({1'b0, job_ff.frac}) * diff;
         end
         B_ECHO: begin
            echo_in = echo_sum[SAMPLE_W-1:0];
         end
         B_MUL: begin
            wet_in = $signed({1'b0, cfg.mix_gain}) * dx;
            fbk_in = $signed({1'b0, cfg.feedback_gain}) * echo_ff;
         end
         B_SUM: begin
            mem_wen         = 1'b1;
            rsp_push        = 1'b1;
            rsp_data.sample = sat24(y_sum);
         end
         B_PASS: begin
            rsp_push = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      e1_ff   <= e1_in;
      prod_ff <= prod_in;
      echo_ff <= echo_in;
      wet_ff  <= wet_in;
      fbk_ff  <= fbk_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wen) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[mem_raddr];
   end

endmodule

`default_nettype wire

/* src/feedback_echo_delay_core.sv */
// ---------------------------------------------------------------------------
// Feedback echo delay core
// Per-channel fractional delay line with linear interpolation, wet/dry mix
// and saturating feedback into the store.
//
//   Port group   Direction  Transfer when          Payload
//   req_*        in         req_push && !req_full  req_sample_in, req_channel
//   rsp_*        out        rsp_pop && !rsp_empty  rsp_sample_out, rsp_channel_out
//   csr_*        in         csr_wen                csr_index, csr_wdata
//
// The front section steps each sample through position, index and close
// states. The back sequencer owns the delay store (one read, one write port)
// and steps an echo sample through read, interpolate, echo, multiply and sum,
// a pass-through sample through a pass state. After reset all store entries
// (CHANNELS * MAX_DEPTH, 524288 by default) are zeroed; req_full stays high
// until that pass has finished. A full result queue stalls the back section
// only; the front keeps going until the queue between them fills.
// ---------------------------------------------------------------------------
`default_nettype none

module feedback_echo_delay_core import fed_pkg::*; #(
   parameter int MAX_DEPTH = FED_MAX_DEPTH,
   parameter int CHANNELS  = FED_CHANNELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  sample_type             req_sample_in,
   input  logic                   req_channel,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output sample_type             rsp_sample_out,
   output logic                   rsp_channel_out,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int MW = $clog2(CHANNELS * MAX_DEPTH);

   typedef struct packed {
      op_type        op;
      sample_type    sample;
      logic          channel;
      logic [MW-1:0] rd0_addr;
      logic [MW-1:0] rd1_addr;
      logic [MW-1:0] wr_addr;
      logic [FRAC_W-1:0] frac;
   } job_type;

   cfg_type cfg;
   logic    hold;
   logic    job_push, job_full, job_pop, job_empty;
   job_type job_wdata, job_rdata;
   logic    rsp_push, rsp_full;
   rsp_type rsp_wdata, rsp_rdata;

   fed_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fed_front #(
      .MAX_DEPTH (MAX_DEPTH),
      .CHANNELS  (CHANNELS),
      .job_type  (job_type)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .hold          (hold),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_sample_in (req_sample_in),
      .req_channel   (req_channel),
      .job_push      (job_push),
      .job_data      (job_wdata),
      .job_full      (job_full)
   );

   fed_queue #(
      .entry_type (job_type),
      .DEPTH      (FED_QUEUE_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wdata),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_rdata),
      .empty     (job_empty)
   );

   fed_back #(
      .MAX_DEPTH (MAX_DEPTH),
      .CHANNELS  (CHANNELS),
      .job_type  (job_type)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_valid (!job_empty),
      .job_data  (job_rdata),
      .job_pop   (job_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata),
      .rsp_full  (rsp_full),
      .clearing  (hold)
   );

   fed_queue #(
      .entry_type (rsp_type),
      .DEPTH      (FED_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wdata),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_rdata),
      .empty     (rsp_empty)
   );

   assign rsp_sample_out  = rsp_rdata.sample;
   assign rsp_channel_out = rsp_rdata.channel;

endmodule

`default_nettype wire
